// ===== sv/gtd_pkg.sv =====
package gtd_pkg;

  localparam int unsigned DEFAULT_MAX_WIDTH = 256;

  localparam int unsigned PIX_W    = 8;
  localparam int unsigned THR_W    = 8;
  localparam int unsigned RWIDTH_W = 9;
  localparam int unsigned CFG_W    = 9;

  localparam logic [THR_W-1:0]    THRESHOLD_RESET = 8'd35;
  localparam logic [RWIDTH_W-1:0] ROW_WIDTH_RESET = 9'd256;
  localparam logic [PIX_W-1:0]    EDGE_OFF        = 8'd255;
  localparam logic [PIX_W-1:0]    EDGE_ON         = 8'd0;

  typedef enum logic [0:0] {
    ACT_PIXEL = 1'b0,
    ACT_FLUSH = 1'b1
  } action_e;

  typedef enum logic [0:0] {
    REG_EDGE_THRESHOLD = 1'b0,
    REG_ROW_WIDTH      = 1'b1
  } cfg_reg_e;

  function automatic logic [PIX_W-1:0] abs_diff(input logic [PIX_W-1:0] a,
                                                input logic [PIX_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

// ===== sv/gtd_if.sv =====
interface gtd_pix_if
  import gtd_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             action;
  logic [PIX_W-1:0] pixel_in;

  modport source (output valid, output action, output pixel_in, input ready);
  modport sink   (input valid, input action, input pixel_in, output ready);
endinterface

interface gtd_res_if
  import gtd_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] edge_pixel;
  logic             frame_end;

  modport source (output valid, output edge_pixel, output frame_end, input ready);
  modport sink   (input valid, input edge_pixel, input frame_end, output ready);
endinterface

// ===== sv/gradient_threshold_edge_detector.sv =====
// Streaming edge detector: one pixel or flush request per clock while the skid register is
// empty; results are registered. The previous row lives in a MAX_WIDTH x 8 line store
// read at two addresses per cycle; the entries for the next column are prefetched from
// the next-state column, so consecutive requests need no gap. A result of row r appears
// when the pixel of row r+1 below it arrives; after the last pixel, one flush per column
// of the clamped row_width drains the last row and the final one carries frame_end. A
// two-entry output stage (result plus skid register) keeps ready high while one waits.
module gradient_threshold_edge_detector
  import gtd_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = DEFAULT_MAX_WIDTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [0:0]          cfg_index_i,
  input  logic [CFG_W-1:0]    cfg_data_i,
  gtd_pix_if.sink             pix_i,
  gtd_res_if.source           res_o
);

  localparam int unsigned CW   = $clog2(MAX_WIDTH);
  localparam int unsigned WW   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned LW   = (WW > RWIDTH_W) ? WW : RWIDTH_W;

  // configuration
  logic [THR_W-1:0]    thr_q;
  logic [RWIDTH_W-1:0] row_width_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q       <= THRESHOLD_RESET;
      row_width_q <= ROW_WIDTH_RESET;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_EDGE_THRESHOLD: thr_q       <= cfg_data_i[THR_W-1:0];
        REG_ROW_WIDTH:      row_width_q <= cfg_data_i[RWIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  logic [LW-1:0] rw_ext;
  logic [LW-1:0] width;
  assign rw_ext = LW'(row_width_q);
  assign width  = (rw_ext < LW'(2)) ? LW'(2) :
                  (rw_ext > LW'(MAX_WIDTH)) ? LW'(MAX_WIDTH) : rw_ext;

  // control state
  logic [CW-1:0] col_cnt_q, col_cnt_d;
  logic [CW-1:0] flush_cnt_q, flush_cnt_d;
  logic          row_ready_q, row_ready_d;

  // line store and prefetch
  logic [PIX_W-1:0] mem_q [MAX_WIDTH];
  logic [PIX_W-1:0] rd0_q, rd1_q;
  logic [PIX_W-1:0] head0_q, head1_q;
  logic [CW-1:0]    ra0, ra1;
  logic             we;
  logic [CW-1:0]    wa;

  // output stage
  logic             out_valid_q, skid_valid_q;
  logic [PIX_W-1:0] out_pix_q, skid_pix_q;
  logic             out_end_q, skid_end_q;

  logic acc, is_flush, flush_ok;
  assign pix_i.ready = !skid_valid_q;
  assign acc         = pix_i.valid && pix_i.ready;
  assign is_flush    = (pix_i.action == ACT_FLUSH);
  assign flush_ok    = row_ready_q && (col_cnt_q == '0);

  logic [CW-1:0]    col;
  logic [LW-1:0]    col_p1;
  logic             right_ok, last;
  logic [PIX_W-1:0] here, right, d_below, d_right, strength;
  logic             new_res;
  logic [PIX_W-1:0] new_pix;
  logic             new_end;

  always_comb begin
    col = is_flush ? flush_cnt_q : col_cnt_q;
    // a pixel that abandons a flush needs the head of the row, not the prefetch
    if (!is_flush && (flush_cnt_q != '0)) begin
      here  = head0_q;
      right = head1_q;
    end else begin
      here  = rd0_q;
      right = rd1_q;
    end
    col_p1   = LW'(col) + LW'(1);
    right_ok = col_p1 < width;
    last     = !right_ok;
    d_below  = is_flush ? '0 : abs_diff(here, pix_i.pixel_in);
    d_right  = right_ok ? abs_diff(here, right) : '0;
    strength = (d_right > d_below) ? d_right : d_below;
    new_pix  = (strength > thr_q) ? EDGE_ON : EDGE_OFF;
    new_end  = is_flush && last;
    new_res  = acc && (is_flush ? flush_ok : row_ready_q);
  end

  always_comb begin
    col_cnt_d   = col_cnt_q;
    flush_cnt_d = flush_cnt_q;
    row_ready_d = row_ready_q;
    we          = 1'b0;
    wa          = col_cnt_q;
    if (acc) begin
      if (!is_flush) begin
        we          = 1'b1;
        flush_cnt_d = '0;
        if (last) begin
          col_cnt_d   = '0;
          row_ready_d = 1'b1;
        end else begin
          col_cnt_d = col_p1[CW-1:0];
        end
      end else if (flush_ok) begin
        if (last) begin
          flush_cnt_d = '0;
          row_ready_d = 1'b0;
        end else begin
          flush_cnt_d = col_p1[CW-1:0];
        end
      end
    end
  end

  // flush_cnt is nonzero only with col_cnt at zero, so the sum is the next column in use
  assign ra0 = col_cnt_d + flush_cnt_d;
  assign ra1 = ra0 + CW'(1);

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= pix_i.pixel_in;
    end
  end

  always_ff @(posedge clk_i) begin
    rd0_q <= (we && (wa == ra0)) ? pix_i.pixel_in : mem_q[ra0];
    rd1_q <= (we && (wa == ra1)) ? pix_i.pixel_in : mem_q[ra1];
    if (we && (wa == CW'(0))) begin
      head0_q <= pix_i.pixel_in;
    end
    if (we && (wa == CW'(1))) begin
      head1_q <= pix_i.pixel_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_cnt_q   <= '0;
      flush_cnt_q <= '0;
      row_ready_q <= 1'b0;
    end else begin
      col_cnt_q   <= col_cnt_d;
      flush_cnt_q <= flush_cnt_d;
      row_ready_q <= row_ready_d;
    end
  end

  // result register plus skid register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (res_o.ready) begin
        skid_valid_q <= 1'b0;
      end
    end else if (new_res) begin
      if (out_valid_q && !res_o.ready) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (res_o.ready) begin
        out_pix_q <= skid_pix_q;
        out_end_q <= skid_end_q;
      end
    end else if (new_res) begin
      if (out_valid_q && !res_o.ready) begin
        skid_pix_q <= new_pix;
        skid_end_q <= new_end;
      end else begin
        out_pix_q <= new_pix;
        out_end_q <= new_end;
      end
    end
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.edge_pixel = out_pix_q;
  assign res_o.frame_end  = out_end_q;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds a result while the result register is empty");

  a_flush_col_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (flush_cnt_q != '0) |-> (col_cnt_q == '0))
    else $error("flush in progress with a partial row");

  a_pixel_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && !is_flush && row_ready_q) |=> out_valid_q)
    else $error("pixel below a stored row produced no result");

  a_frame_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && is_flush && flush_ok && last) |=> (!row_ready_q && (flush_cnt_q == '0)))
    else $error("last flush did not return to the empty state");

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import gtd_pkg::*;

  localparam int QUIET_LIMIT = 2000;

  typedef struct packed {
    logic [PIX_W-1:0] edge_pixel;
    logic             frame_end;
  } edge_res_t;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we;
  cfg_reg_e         cfg_index;
  logic [CFG_W-1:0] cfg_data;

  gtd_pix_if pix_if ();
  gtd_res_if res_if ();

  gradient_threshold_edge_detector u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .pix_i       (pix_if),
    .res_o       (res_if)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // predictor state: previous row, position in the row, drain position
  logic [PIX_W-1:0]    line_mem [DEFAULT_MAX_WIDTH];
  int                  next_col;
  int                  drain_col;
  bit                  row_full;
  logic [THR_W-1:0]    thr_q;
  logic [RWIDTH_W-1:0] width_q;

  edge_res_t edge_expect_q[$];
  int        mismatches;
  int        reqs_sent;
  int        src_idle_pct;
  int        snk_stall_pct;
  int        quiet_cycles;

  function automatic int active_width();
    if (width_q < 2) return 2;
    if (width_q > DEFAULT_MAX_WIDTH) return DEFAULT_MAX_WIDTH;
    return int'(width_q);
  endfunction

  function automatic logic [PIX_W-1:0] edge_grade(int col, int w, bit has_below,
                                                   logic [PIX_W-1:0] below);
    int here;
    int strength;
    int d;
    here = line_mem[col];
    strength = 0;
    if (has_below) strength = (here > below) ? here - below : below - here;
    if (col + 1 < w) begin
      d = here - int'(line_mem[col + 1]);
      if (d < 0) d = -d;
      if (d > strength) strength = d;
    end
    return (strength > thr_q) ? EDGE_ON : EDGE_OFF;
  endfunction

  function automatic void detector_request(action_e act, logic [PIX_W-1:0] pix);
    int        w;
    int        col;
    edge_res_t res;
    w = active_width();
    if (act == ACT_PIXEL) begin
      col = next_col;
      drain_col = 0;
      if (row_full) begin
        res.edge_pixel = edge_grade(col, w, 1'b1, pix);
        res.frame_end = 1'b0;
        edge_expect_q.push_back(res);
      end
      line_mem[col] = pix;
      if (col + 1 >= w) begin
        next_col = 0;
        row_full = 1'b1;
      end else begin
        next_col = col + 1;
      end
    end else if (row_full && next_col == 0) begin
      // drain of the last row; a flush anywhere else does nothing
      col = drain_col;
      res.edge_pixel = edge_grade(col, w, 1'b0, '0);
      res.frame_end = (col + 1 >= w);
      edge_expect_q.push_back(res);
      if (res.frame_end) begin
        drain_col = 0;
        next_col = 0;
        row_full = 1'b0;
      end else begin
        drain_col = col + 1;
      end
    end
  endfunction

  task automatic send_req(input action_e act, input logic [PIX_W-1:0] pix);
    while ($urandom_range(99) < src_idle_pct) begin
      pix_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix_if.valid <= 1'b1;
    pix_if.action <= act;
    pix_if.pixel_in <= pix;
    do @(posedge clk_i); while (!pix_if.ready);
    detector_request(act, pix);
    reqs_sent++;
  endtask

  // hold off the sender until every expected result is out
  task automatic settle();
    pix_if.valid <= 1'b0;
    do @(posedge clk_i); while (edge_expect_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
    if (idx == REG_EDGE_THRESHOLD) thr_q = data[THR_W-1:0];
    else width_q = data[RWIDTH_W-1:0];
  endtask

  task automatic send_row(input int w);
    for (int c = 0; c < w; c++) send_req(ACT_PIXEL, PIX_W'($urandom_range(255)));
  endtask

  // reset threshold, width 1 (acts as 2); flush with no row, mid-row,
  // abandoned by a pixel, then the full drain
  task automatic test_flush_corners();
    settle();
    write_reg(REG_ROW_WIDTH, 9'd1);
    send_req(ACT_FLUSH, 8'd255);
    send_req(ACT_PIXEL, 8'd0);
    send_req(ACT_PIXEL, 8'd36);
    send_req(ACT_PIXEL, 8'd35);
    send_req(ACT_PIXEL, 8'd255);
    send_req(ACT_PIXEL, 8'd0);
    send_req(ACT_FLUSH, 8'd0);
    send_req(ACT_PIXEL, 8'd255);
    send_req(ACT_FLUSH, 8'd170);
    send_req(ACT_PIXEL, 8'd128);
    send_req(ACT_PIXEL, 8'd129);
    send_req(ACT_FLUSH, 8'd85);
    send_req(ACT_FLUSH, 8'd0);
  endtask

  // width narrowed below the current column in the middle of a row
  task automatic test_width_shrink();
    settle();
    write_reg(REG_EDGE_THRESHOLD, 9'd255);
    write_reg(REG_ROW_WIDTH, 9'd5);
    for (int c = 0; c < 8; c++) send_req(ACT_PIXEL, c[0] ? 8'd255 : 8'd0);
    settle();
    write_reg(REG_ROW_WIDTH, 9'd2);
    send_req(ACT_PIXEL, 8'd0);
    send_req(ACT_PIXEL, 8'd255);
    send_req(ACT_PIXEL, 8'd0);
    send_req(ACT_FLUSH, 8'd0);
    send_req(ACT_FLUSH, 8'd0);
  endtask

  // a single row at the full line store width, then its drain
  task automatic test_widest_row();
    settle();
    write_reg(REG_EDGE_THRESHOLD, 9'd2);
    write_reg(REG_ROW_WIDTH, 9'h1FF);
    for (int c = 0; c < DEFAULT_MAX_WIDTH; c++)
      send_req(ACT_PIXEL, ($urandom_range(3) == 0) ? PIX_W'($urandom_range(255)) : c[7:0]);
    for (int c = 0; c < DEFAULT_MAX_WIDTH; c++) send_req(ACT_FLUSH, PIX_W'($urandom()));
  endtask

  task automatic test_random_frames(input int budget);
    int stop_at;
    int w;
    int rows;
    int pick;
    logic [CFG_W-1:0] thr_data;
    logic [CFG_W-1:0] width_data;
    stop_at = reqs_sent + budget;
    while (reqs_sent < stop_at) begin
      settle();
      pick = $urandom_range(9);
      thr_data = (pick == 0) ? 9'd0 : (pick == 1) ? 9'd255 : CFG_W'($urandom_range(511));
      write_reg(REG_EDGE_THRESHOLD, thr_data);
      pick = $urandom_range(9);
      width_data = (pick < 3) ? CFG_W'(pick) : CFG_W'($urandom_range(12, 3));
      write_reg(REG_ROW_WIDTH, width_data);
      w = active_width();
      rows = $urandom_range(5, 1);
      if ($urandom_range(7) == 0) send_req(ACT_FLUSH, PIX_W'($urandom()));
      for (int r = 0; r < rows; r++) begin
        for (int c = 0; c < w; c++) begin
          if (c > 0 && $urandom_range(15) == 0) send_req(ACT_FLUSH, PIX_W'($urandom()));
          send_req(ACT_PIXEL, PIX_W'($urandom_range(255)));
        end
        // partial drain, broken off by the next row
        if (r < rows - 1 && $urandom_range(4) == 0)
          repeat ($urandom_range(w - 1, 1)) send_req(ACT_FLUSH, PIX_W'($urandom()));
      end
      for (int c = 0; c < w; c++) send_req(ACT_FLUSH, PIX_W'($urandom()));
      if ($urandom_range(9) == 0) send_req(ACT_FLUSH, PIX_W'($urandom()));
    end
  endtask

  // result check and receiver stalls
  always @(posedge clk_i) begin
    edge_res_t exp_res;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (edge_expect_q.size() == 0) begin
        $error("unexpected result: edge_pixel %0d frame_end %0d",
               res_if.edge_pixel, res_if.frame_end);
        mismatches++;
      end else begin
        exp_res = edge_expect_q.pop_front();
        if (res_if.edge_pixel !== exp_res.edge_pixel) begin
          $error("edge_pixel: expected %0d, actual %0d", exp_res.edge_pixel,
                 res_if.edge_pixel);
          mismatches++;
        end
        if (res_if.frame_end !== exp_res.frame_end) begin
          $error("frame_end: expected %0d, actual %0d", exp_res.frame_end,
                 res_if.frame_end);
          mismatches++;
        end
      end
    end
    res_if.ready <= rst_ni && ($urandom_range(99) >= snk_stall_pct);
  end

  always @(posedge clk_i) begin
    if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("gradient_threshold_edge_detector: mismatch");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_EDGE_THRESHOLD;
    cfg_data = '0;
    pix_if.valid = 1'b0;
    pix_if.action = ACT_PIXEL;
    pix_if.pixel_in = '0;
    res_if.ready = 1'b0;
    mismatches = 0;
    reqs_sent = 0;
    quiet_cycles = 0;
    src_idle_pct = 0;
    snk_stall_pct = 0;
    next_col = 0;
    drain_col = 0;
    row_full = 1'b0;
    thr_q = THRESHOLD_RESET;
    width_q = ROW_WIDTH_RESET;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_flush_corners();
    test_width_shrink();
    test_random_frames(160);
    src_idle_pct = 67;
    test_random_frames(160);
    src_idle_pct = 0;
    snk_stall_pct = 67;
    test_random_frames(160);
    src_idle_pct = 9;
    snk_stall_pct = 9;
    test_widest_row();
    test_random_frames(160);
    settle();

    if (mismatches == 0) begin
      $display("gradient_threshold_edge_detector: match");
    end else begin
      $display("gradient_threshold_edge_detector: mismatch");
    end
    $finish;
  end

endmodule
